// ===== rtl/mrk_pkg.sv =====
package mrk_pkg;
    localparam int MaxLeaves = 256;
    localparam int WordsPerNode = 4;
    localparam int NodeAw = $clog2(MaxLeaves);
    localparam int MemAw = $clog2(MaxLeaves * WordsPerNode);
    localparam int CntW = $clog2(MaxLeaves + 1);

    localparam logic [255:0] ShaIv = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] sha_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction
endpackage

// ===== rtl/mrk_sha_core.sv =====
module mrk_sha_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [511:0] i_block,
    input  logic [255:0] i_hin,
    output logic         o_done,
    output logic [255:0] o_hout
);
    import mrk_pkg::*;

    logic [31:0]  r_w [16];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [255:0] r_hin;
    logic [5:0]   r_rnd;
    logic         r_run, r_done;
    logic [31:0]  s0, s1, wn, t1, t2, ch, mj, se, sa;

    // round and schedule logic
    always_comb begin
        s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
             ^ (r_w[14] >> 10);
        wn = r_w[0] + s0 + r_w[9] + s1;
        se = {r_e[5:0], r_e[31:6]} ^ {r_e[10:0], r_e[31:11]} ^ {r_e[24:0], r_e[31:25]};
        ch = (r_e & r_f) ^ (~r_e & r_g);
        sa = {r_a[1:0], r_a[31:2]} ^ {r_a[12:0], r_a[31:13]} ^ {r_a[21:0], r_a[31:22]};
        mj = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
        t1 = r_h + se + ch + sha_k(r_rnd) + r_w[0];
        t2 = sa + mj;
    end

    // 64 rounds, one per cycle
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_rnd <= '0;
        end else if (i_start && !r_run) begin
            r_run <= 1'b1;
            r_rnd <= '0;
            r_hin <= i_hin;
            for (int i = 0; i < 16; i++) r_w[i] <= i_block[511 - 32*i -: 32];
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= i_hin;
        end else if (r_run) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wn;
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <=
                {t1 + t2, r_a, r_b, r_c, r_d + t1, r_e, r_f, r_g};
            r_rnd <= r_rnd + 6'd1;
            if (r_rnd == 6'd63) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_hout = {r_hin[255:224] + r_a, r_hin[223:192] + r_b, r_hin[191:160] + r_c,
                     r_hin[159:128] + r_d, r_hin[127:96] + r_e, r_hin[95:64] + r_f,
                     r_hin[63:32] + r_g, r_hin[31:0] + r_h};
endmodule

// ===== rtl/merkle_root_engine.sv =====
// a leaf without last is written in S_WLEAF; no new leaf is taken while busy;
// a close hashes level by level, per parent S_RD reads both children, S_H1 and
// S_H2 run the two sha passes and S_WR writes it; the sha loop sets the close time
// reset: synchronous active-low clears counters and control; node memory undefined
// the receiver cannot stall: o_valid pulses for one cycle with the root
module merkle_root_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_leaf_w0,
    input  logic [63:0] i_leaf_w1,
    input  logic [63:0] i_leaf_w2,
    input  logic [63:0] i_leaf_w3,
    input  logic        i_last_leaf,
    input  logic        i_empty_batch,
    output logic        o_valid,
    output logic [63:0] o_root_w0,
    output logic [63:0] o_root_w1,
    output logic [63:0] o_root_w2,
    output logic [63:0] o_root_w3,
    output logic        o_capacity_exceeded
);
    import mrk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WLEAF, S_LEVEL, S_RD, S_H1, S_H2, S_WR, S_RDROOT, S_OUT
    } t_state;

    t_state       r_st;
    logic [63:0]  mem [MaxLeaves*WordsPerNode];
    logic [63:0]  r_rdata;
    logic [CntW-1:0] r_cnt, r_n, r_next, r_i;
    logic         r_ovf;
    logic [255:0] r_leaf;
    logic [1:0]   r_wi;
    logic [3:0]   r_ri;
    logic         r_rv;
    logic [511:0] r_blk;
    logic [255:0] r_hv;
    logic         r_hs;
    logic         r_close;
    logic         mem_we;
    logic [MemAw-1:0] mem_wa, mem_ra;
    logic [63:0]  mem_wd;
    logic         sha_done;
    logic [255:0] sha_out;
    logic [CntW-1:0] rd_node;
    logic [CntW:0]   lnode;

    // memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    // operand node address: left for word 0..3, right (or left again if none) for 4..7
    always_comb begin
        lnode = {r_i, 1'b0};
        if (r_ri[2] && (lnode + 1'b1 < {1'b0, r_n})) lnode = lnode + 1'b1;
        rd_node = lnode[CntW-1:0];
        mem_ra = {rd_node[NodeAw-1:0], r_ri[1:0]};
        if (r_st == S_RDROOT) mem_ra = {{NodeAw{1'b0}}, r_ri[1:0]};
        mem_we = 1'b0;
        mem_wa = {r_cnt[NodeAw-1:0], r_wi};
        mem_wd = r_leaf[255 - 64*r_wi -: 64];
        if (r_st == S_WLEAF) mem_we = 1'b1;
        if (r_st == S_WR) begin
            mem_we = 1'b1;
            mem_wa = {r_i[NodeAw-1:0], r_wi};
            mem_wd = r_hv[255 - 64*r_wi -: 64];
        end
    end

    mrk_sha_core u_sha (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_hs), .i_block(r_blk),
        .i_hin((r_st == S_H1) ? ShaIv : r_hv), .o_done(sha_done), .o_hout(sha_out)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        r_hs <= 1'b0;
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: if (start) begin
                    r_leaf <= {i_leaf_w0, i_leaf_w1, i_leaf_w2, i_leaf_w3};
                    r_wi <= '0;
                    r_close <= i_empty_batch || i_last_leaf;
                    if (i_empty_batch) r_st <= S_LEVEL;
                    else if (r_cnt < CntW'(MaxLeaves)) r_st <= S_WLEAF;
                    else begin
                        r_ovf <= 1'b1;
                        r_st <= i_last_leaf ? S_LEVEL : S_IDLE;
                    end
                    r_n <= r_cnt;
                end
                S_WLEAF: begin
                    r_wi <= r_wi + 2'd1;
                    if (r_wi == 2'd3) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_n <= r_cnt + 1'b1;
                        r_st <= r_close ? S_LEVEL : S_IDLE;
                    end
                end
                S_LEVEL: begin
                    r_i <= '0;
                    r_ri <= '0;
                    r_rv <= 1'b0;
                    r_next <= CntW'(({1'b0, r_n} + 1'b1) >> 1);
                    if (r_n == '0) begin
                        r_hv <= '0;
                        r_st <= S_OUT;
                    end else if (r_n == CntW'(1)) begin
                        r_ri <= '0;
                        r_st <= S_RDROOT;
                    end else r_st <= S_RD;
                end
                S_RD: begin
                    r_rv <= 1'b1;
                    if (r_rv) r_blk <= {r_blk[447:0], r_rdata};
                    if (r_ri != 4'd8) r_ri <= r_ri + 4'd1;
                    if (r_ri == 4'd8) begin
                        r_hs <= 1'b1;
                        r_st <= S_H1;
                    end
                end
                S_H1: if (sha_done) begin
                    r_hv <= sha_out;
                    r_blk <= {32'h80000000, 448'd0, 32'd512};
                    r_hs <= 1'b1;
                    r_st <= S_H2;
                end
                S_H2: if (sha_done) begin
                    r_hv <= sha_out;
                    r_wi <= '0;
                    r_st <= S_WR;
                end
                S_WR: begin
                    r_wi <= r_wi + 2'd1;
                    if (r_wi == 2'd3) begin
                        r_ri <= '0;
                        r_rv <= 1'b0;
                        if (r_i + 1'b1 == r_next) begin
                            r_n <= r_next;
                            r_st <= S_LEVEL;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_st <= S_RD;
                        end
                    end
                end
                S_RDROOT: begin
                    r_rv <= 1'b1;
                    if (r_rv) r_hv <= {r_hv[191:0], r_rdata};
                    if (r_ri != 4'd4) r_ri <= r_ri + 4'd1;
                    if (r_ri == 4'd4) r_st <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    {o_root_w0, o_root_w1, o_root_w2, o_root_w3} <= r_hv;
                    o_capacity_exceeded <= r_ovf;
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_st != S_IDLE);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxLeaves)) else $error("leaf count beyond capacity");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than a cycle");
    a_out_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_cnt == '0) && !r_ovf) else $error("batch state not cleared");
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    // one expected root with its overflow flag
    typedef struct {
        logic [255:0] root;
        logic         cap;
    } root_exp_t;

    // root predictor and store of expected roots
    class root_scoreboard;
        logic [255:0] leaves [mrk_pkg::MaxLeaves];
        int unsigned  n_leaves;
        bit           dropped;
        root_exp_t    pending [$];
        int           n_err;

        // sha round constants
        localparam logic [31:0] RoundK [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

        function automatic logic [31:0] ror32(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // one compression of a 512-bit block, word 0 in the top bits
        function automatic logic [255:0] compress(logic [255:0] h, logic [511:0] blk);
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
            for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
            for (int i = 16; i < 64; i++) begin
                s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            {a, b, c, d, e, f, g, hh} = h;
            for (int i = 0; i < 64; i++) begin
                t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
                     + ((e & f) ^ (~e & g)) + RoundK[i] + w[i];
                t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
                     + ((a & b) ^ (a & c) ^ (b & c));
                hh = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            return {h[255:224] + a, h[223:192] + b, h[191:160] + c, h[159:128] + d,
                    h[127:96] + e, h[95:64] + f, h[63:32] + g, h[31:0] + hh};
        endfunction

        // parent = sha256(left || right), padding block fixed for 64 bytes
        function automatic logic [255:0] parent_of(logic [255:0] l, logic [255:0] r);
            logic [255:0] h;
            h = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
            h = compress(h, {l, r});
            h = compress(h, {32'h80000000, 448'd0, 32'd512});
            return h;
        endfunction

        function new();
            n_leaves = 0;
            dropped  = 0;
            n_err    = 0;
        endfunction

        // accepted request: store the leaf, and on close predict the root
        function void note_request(logic [255:0] leaf, bit last, bit empty);
            root_exp_t   x;
            int unsigned n, nxt, r;
            if (!empty) begin
                if (n_leaves < mrk_pkg::MaxLeaves) begin
                    leaves[n_leaves] = leaf;
                    n_leaves++;
                end else begin
                    dropped = 1;
                end
                if (!last) return;
            end
            n = n_leaves;
            while (n > 1) begin
                nxt = (n + 1) / 2;
                for (int i = 0; i < nxt; i++) begin
                    r = (2*i + 1 < n) ? 2*i + 1 : 2*i;
                    leaves[i] = parent_of(leaves[2*i], leaves[r]);
                end
                n = nxt;
            end
            x.root = (n_leaves == 0) ? 256'd0 : leaves[0];
            x.cap  = dropped;
            pending.push_back(x);
            n_leaves = 0;
            dropped  = 0;
        endfunction

        function void check_root(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                                 logic [63:0] w3, logic cap);
            root_exp_t x;
            if (pending.size() == 0) begin
                $error("unexpected root %h%h%h%h", w0, w1, w2, w3);
                n_err++;
                return;
            end
            x = pending.pop_front();
            if (w0 !== x.root[255:192]) begin
                $error("root_w0 exp %h got %h", x.root[255:192], w0); n_err++;
            end
            if (w1 !== x.root[191:128]) begin
                $error("root_w1 exp %h got %h", x.root[191:128], w1); n_err++;
            end
            if (w2 !== x.root[127:64]) begin
                $error("root_w2 exp %h got %h", x.root[127:64], w2); n_err++;
            end
            if (w3 !== x.root[63:0]) begin
                $error("root_w3 exp %h got %h", x.root[63:0], w3); n_err++;
            end
            if (cap !== x.cap) begin
                $error("capacity_exceeded exp %0b got %0b", x.cap, cap); n_err++;
            end
        endfunction
    endclass

    localparam int StallLimit = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_leaf_w0 = '0, i_leaf_w1 = '0, i_leaf_w2 = '0, i_leaf_w3 = '0;
    logic        i_last_leaf = 1'b0;
    logic        i_empty_batch = 1'b0;
    logic        o_valid;
    logic [63:0] o_root_w0, o_root_w1, o_root_w2, o_root_w3;
    logic        o_capacity_exceeded;

    root_scoreboard sb = new();
    int             idle_cycles = 0;
    int             gap_pct = 0;

    always #5 i_clk = ~i_clk;

    merkle_root_engine u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_leaf_w0          (i_leaf_w0),
        .i_leaf_w1          (i_leaf_w1),
        .i_leaf_w2          (i_leaf_w2),
        .i_leaf_w3          (i_leaf_w3),
        .i_last_leaf        (i_last_leaf),
        .i_empty_batch      (i_empty_batch),
        .o_valid            (o_valid),
        .o_root_w0          (o_root_w0),
        .o_root_w1          (o_root_w1),
        .o_root_w2          (o_root_w2),
        .o_root_w3          (o_root_w3),
        .o_capacity_exceeded(o_capacity_exceeded)
    );

    // result monitor and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_root(o_root_w0, o_root_w1, o_root_w2, o_root_w3, o_capacity_exceeded);
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [255:0] rand_leaf();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    // drive one request, hold until taken, then maybe drop start for a random gap
    task automatic send_request(logic [255:0] leaf, bit last, bit empty);
        start         <= 1'b1;
        {i_leaf_w0, i_leaf_w1, i_leaf_w2, i_leaf_w3} <= leaf;
        i_last_leaf   <= last;
        i_empty_batch <= empty;
        do @(posedge i_clk); while (busy);
        sb.note_request(leaf, last, empty);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // a batch of n leaves, closed by last or by an empty flag
    task automatic send_batch(int n, bit close_by_empty);
        for (int i = 0; i < n; i++)
            send_request(rand_leaf(), (i == n - 1) && !close_by_empty, 1'b0);
        if (close_by_empty || n == 0)
            send_request(rand_leaf(), $urandom_range(1), 1'b1);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty batches, single leaves at extremes, a pair, odd and even batches
        send_request('1, 1'b1, 1'b1);
        send_request('0, 1'b0, 1'b1);
        send_request('1, 1'b1, 1'b0);
        send_request('0, 1'b1, 1'b0);
        send_request('1, 1'b0, 1'b0);
        send_request('0, 1'b1, 1'b0);
        send_batch(3, 0);
        send_batch(2, 1);
        send_batch(5, 0);
        send_batch(1, 1);

        // pause until every root is back
        wait_drained();

        // random batches, with one full store and one overflow
        sent = 0;
        for (int b = 0; sent < 950; b++) begin
            int n;
            bit ce;
            case (b % 4)
                0: gap_pct = 0;
                1: gap_pct = 52;
                2: gap_pct = 0;
                default: gap_pct = 19;
            endcase
            if (b == 20) n = mrk_pkg::MaxLeaves;
            else if (b == 45) n = mrk_pkg::MaxLeaves + 3;
            else if (b % 10 == 7) n = 0;
            else n = $urandom_range(1, 9);
            ce = ($urandom_range(4) == 0);
            send_batch(n, ce);
            sent += n + ((ce || n == 0) ? 1 : 0);
        end

        wait_drained();
        if (sb.n_err == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mrk_pkg.sv
rtl/mrk_sha_core.sv
rtl/merkle_root_engine.sv
tb/sv/tb_top.sv
